// ----- rtl/glyph_quad_layout_macros.svh -----
// Assertion macros for the glyph quad layout block.
// Used by glyph_quad_layout.sv; expects clk and rst_n in scope.
`ifndef GLYPH_QUAD_LAYOUT_MACROS_SVH
`define GLYPH_QUAD_LAYOUT_MACROS_SVH

// same-cycle implication, disabled in reset
`define GLQ_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define GLQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/glq_pkg.sv -----
// Shared types, constants and the glyph advance table for glyph_quad_layout.
// No dependencies.
package glq_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CODE_W     = 8;
  localparam int PEN_X_W    = 20;
  localparam int PEN_Y_W    = 16;
  localparam int POS_W      = 20;
  localparam int TEX_W      = 17;
  localparam int RGBA_W     = 32;
  localparam int CORNER_W   = 2;
  localparam int AX_W       = 22;
  localparam int NY_W       = 28;
  localparam int UX_W       = 23;
  localparam int UY_W       = 24;
  localparam int RECIP_W    = 24;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_GLYPH_SCALE  = 3'd2,
    REG_TEXT_COLOR   = 3'd3,
    REG_HALF_TEXEL_U = 3'd4,
    REG_HALF_TEXEL_V = 3'd5
  } cfg_reg_t;

  localparam logic [CORNER_W-1:0] CORNER_RT = 2'd0;
  localparam logic [CORNER_W-1:0] CORNER_RB = 2'd1;
  localparam logic [CORNER_W-1:0] CORNER_LB = 2'd2;
  localparam logic [CORNER_W-1:0] CORNER_LT = 2'd3;

  localparam logic [CODE_W-1:0] CHAR_LF = 8'd10;
  localparam logic [CODE_W-1:0] CHAR_CR = 8'd13;

  // floor(u/5) = (u*RECIP_X) >> 26 exact for u < 2^23
  localparam logic [RECIP_W-1:0] RECIP_X    = 24'd13421773;
  localparam int                 RECIP_X_SH = 26;
  // floor(u/15) = (u*RECIP_Y) >> 27 exact for u < 2^24
  localparam logic [RECIP_W-1:0] RECIP_Y    = 24'd8947849;
  localparam int                 RECIP_Y_SH = 27;

  // dividend limits: 5*2^19 and 15*2^19
  localparam logic signed [UX_W:0]   SAT_X_HI = 24'sd2621440;
  localparam logic signed [UX_W:0]   SAT_X_LO = -24'sd2621440;
  localparam logic signed [NY_W+1:0] SAT_Y_HI = 30'sd7864320;
  localparam logic signed [NY_W+1:0] SAT_Y_LO = -30'sd7864320;

  localparam logic signed [POS_W-1:0] POS_MAX = 20'sh7FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 20'sh80000;

  typedef struct packed {
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic [11:0]        glyph_scale;
    logic [31:0]        text_color;
    logic [15:0]        half_texel_u;
    logic [15:0]        half_texel_v;
  } glq_cfg_t;

  typedef struct packed {
    logic                   brk;
    logic [CODE_W-1:0]      code;
    logic signed [AX_W-1:0] ax;
    logic signed [NY_W-1:0] ny;
  } glq_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } glq_qstat_t;

  // pen advance in pixels per unit scale
  function automatic logic [4:0] advance_of(input logic [CODE_W-1:0] ch);
    logic [4:0] w;
    unique case (ch) inside
      // i l I space / \ ; : . ,
      8'd105, 8'd108, 8'd73, 8'd32, 8'd47, 8'd92, 8'd59, 8'd58, 8'd46, 8'd44:
        w = 5'd5;
      // [ ] | ( ) j f t
      8'd91, 8'd93, 8'd124, 8'd40, 8'd41, 8'd106, 8'd102, 8'd116:
        w = 5'd6;
      // d h o p n F +
      8'd100, 8'd104, 8'd111, 8'd112, 8'd110, 8'd70, 8'd43:
        w = 5'd11;
      // digits e k a c u y v L
      [8'd48:8'd57], 8'd101, 8'd107, 8'd97, 8'd99, 8'd117, 8'd121, 8'd118, 8'd76:
        w = 5'd10;
      8'd115:                          w = 5'd9;   // s
      8'd114, 8'd74, 8'd45, 8'd61:     w = 5'd8;   // r J - =
      8'd87:                           w = 5'd17;  // W
      8'd109, 8'd119, 8'd77, 8'd78:    w = 5'd15;  // m w M N
      8'd82:                           w = 5'd13;  // R
      default:                         w = 5'd12;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/glyph_quad_layout.sv -----
// Glyph quad layout: one character in, four quad vertices out.
// The first vertex passes through the queue, then the issue, multiply and output
// registers. The back end issues one vertex per cycle from the queue head while
// the queue is not empty and the output is not stalled.
// Reset (rst_n, synchronous, active low): pens cleared, queue and pipeline
// emptied, registers back to their defaults.
`include "glyph_quad_layout_macros.svh"

module glyph_quad_layout #(
  parameter int QUEUE_DEPTH = glq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [glq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [glq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] char_code
  input  logic                              in_tlast,   // end_of_string
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [19:0] pos_x, [39:20] pos_y, [56:40] tex_u, [73:57] tex_v,
  // [105:74] rgba, [111:106] zero
  output logic [111:0]                      out_tdata,
  output logic [glq_pkg::CORNER_W-1:0]      out_tuser,  // [1:0] corner
  output logic                              out_tlast   // last_vertex
);
  import glq_pkg::*;

  glq_cfg_t            cfg_r, cfg_nxt;
  glq_qstat_t          q_stat;
  glq_item_t           q_in, q_out;
  logic                q_push, q_pop;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [TEX_W-1:0]    tex_u, tex_v;
  logic [RGBA_W-1:0]   rgba;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:     cfg_nxt.origin_x     = $signed(cfg_data[10:0]);
        REG_ORIGIN_Y:     cfg_nxt.origin_y     = $signed(cfg_data[10:0]);
        REG_GLYPH_SCALE:  cfg_nxt.glyph_scale  = cfg_data[11:0];
        REG_TEXT_COLOR:   cfg_nxt.text_color   = cfg_data[31:0];
        REG_HALF_TEXEL_U: cfg_nxt.half_texel_u = cfg_data[15:0];
        REG_HALF_TEXEL_V: cfg_nxt.half_texel_v = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.glyph_scale  <= 12'd256;
      cfg_r.text_color   <= 32'hFFFF_FFFF;
      cfg_r.half_texel_u <= 16'd128;
      cfg_r.half_texel_v <= 16'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  glq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_code  (in_tdata[7:0]),
    .in_eos   (in_tlast),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  glq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .stat  (q_stat)
  );

  glq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_stat     (q_stat),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_corner (out_tuser),
    .out_pos_x  (pos_x),
    .out_pos_y  (pos_y),
    .out_tex_u  (tex_u),
    .out_tex_v  (tex_v),
    .out_rgba   (rgba),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b0, rgba, tex_v, tex_u, pos_y, pos_x};

  `GLQ_ASSERT_NOW(a_last_on_lt, out_tvalid, out_tlast == (out_tuser == CORNER_LT), "last_vertex not on left-top corner")
  `GLQ_ASSERT_NEXT(a_corner_seq, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tuser == $past(out_tuser) + 2'd1), "vertex of a character missing or out of order")
  `GLQ_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty, "queue popped while empty")

endmodule

// ----- rtl/glq_front.sv -----
// Front end: accepts characters, keeps the pen offsets, builds queue items.
// Depends on glq_pkg.
module glq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glq_pkg::glq_cfg_t             cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [glq_pkg::CODE_W-1:0]    in_code,
  input  logic                          in_eos,
  input  glq_pkg::glq_qstat_t           q_stat,
  output logic                          q_push,
  output glq_pkg::glq_item_t            q_item
);
  import glq_pkg::*;

  logic [PEN_X_W-1:0]     pen_x_r, pen_x_nxt;
  logic [PEN_Y_W-1:0]     pen_y_r, pen_y_nxt;
  logic                   accept;
  logic                   brk;
  logic [16:0]            adv_prod;
  logic [PEN_X_W:0]       nx;
  logic [PEN_Y_W:0]       ny_pen;
  logic signed [17:0]     oy_sum;
  logic signed [AX_W-1:0] ax;
  logic signed [NY_W-1:0] ny;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign q_push   = accept;
  assign brk      = (in_code == CHAR_LF) || (in_code == CHAR_CR);

  // left edge in Q.8 pixels, top edge in Q.8 pixels scaled by 4
  assign ax     = $signed({{3{cfg.origin_x[10]}}, cfg.origin_x, 8'b0})
                + $signed({2'b0, pen_x_r}) - 22'sd2560;
  assign oy_sum = $signed({{7{cfg.origin_y[10]}}, cfg.origin_y})
                + $signed({2'b0, pen_y_r});
  assign ny     = $signed({oy_sum, 10'b0}) - 28'sd4608;

  assign q_item.brk  = brk;
  assign q_item.code = in_code;
  assign q_item.ax   = ax;
  assign q_item.ny   = ny;

  assign adv_prod = {12'b0, advance_of(in_code)} * {5'b0, cfg.glyph_scale};
  assign nx       = {1'b0, pen_x_r} + {4'b0, adv_prod};
  assign ny_pen   = {1'b0, pen_y_r} + 17'd16;

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (accept) begin
      if (brk) begin
        pen_x_nxt = '0;
        pen_y_nxt = ny_pen[PEN_Y_W] ? '1 : ny_pen[PEN_Y_W-1:0];
      end else begin
        pen_x_nxt = nx[PEN_X_W] ? '1 : nx[PEN_X_W-1:0];
      end
      if (in_eos) begin
        pen_x_nxt = '0;
        pen_y_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

// ----- rtl/glq_queue.sv -----
// Small item queue between the front and back ends.
// Depends on glq_pkg.
module glq_queue #(
  parameter int DEPTH = glq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  glq_pkg::glq_item_t  din,
  input  logic                pop,
  output glq_pkg::glq_item_t  dout,
  output glq_pkg::glq_qstat_t stat
);
  import glq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  glq_item_t       slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign dout       = slots_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/glq_back.sv -----
// Back end: expands each queued character into four vertices through a
// three-stage pipeline (operand select, reciprocal multiply, output). Depends on glq_pkg.
module glq_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  glq_pkg::glq_cfg_t                  cfg,
  input  glq_pkg::glq_qstat_t                q_stat,
  input  glq_pkg::glq_item_t                 q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [glq_pkg::CORNER_W-1:0]       out_corner,
  output logic signed [glq_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [glq_pkg::POS_W-1:0]   out_pos_y,
  output logic [glq_pkg::TEX_W-1:0]          out_tex_u,
  output logic [glq_pkg::TEX_W-1:0]          out_tex_v,
  output logic [glq_pkg::RGBA_W-1:0]         out_rgba,
  output logic                               out_last
);
  import glq_pkg::*;

  logic                   adv, issue;
  logic [CORNER_W-1:0]    corner_r;
  logic                   use_right, use_bottom;

  // issue stage
  logic [16:0]            scale30;
  logic [18:0]            scale120;
  logic signed [AX_W-1:0] ax_sel;
  logic signed [NY_W-1:0] ny_sel;
  logic signed [UX_W:0]   m_x, u_x_full;
  logic signed [NY_W+1:0] m_y, u_y_full;
  logic [3:0]             col, row;
  logic [4:0]             colp1, rowp1;
  logic [TEX_W-1:0]       tu_l, tv_t;
  logic signed [TEX_W:0]  tu_r_full, tv_b_full;
  logic [TEX_W-1:0]       tu_r, tv_b;

  logic                   s1_v_r;
  logic [CORNER_W-1:0]    s1_corner_r;
  logic                   s1_brk_r, s1_hi_x_r, s1_lo_x_r, s1_hi_y_r, s1_lo_y_r;
  logic [UX_W-1:0]        s1_ux_r;
  logic [UY_W-1:0]        s1_uy_r;
  logic [TEX_W-1:0]       s1_tu_r, s1_tv_r;

  // multiply stage
  logic [UX_W+RECIP_W-1:0] prod_x;
  logic [UY_W+RECIP_W-1:0] prod_y;

  logic                   s2_v_r;
  logic [CORNER_W-1:0]    s2_corner_r;
  logic                   s2_brk_r, s2_hi_x_r, s2_lo_x_r, s2_hi_y_r, s2_lo_y_r;
  logic [POS_W-1:0]       s2_qx_r, s2_qy_r;
  logic [TEX_W-1:0]       s2_tu_r, s2_tv_r;

  // output stage
  logic signed [POS_W-1:0] px, py;
  logic                    out_valid_r;
  logic [CORNER_W-1:0]     out_corner_r;
  logic signed [POS_W-1:0] out_pos_x_r, out_pos_y_r;
  logic [TEX_W-1:0]        out_tex_u_r, out_tex_v_r;

  assign adv   = !out_valid_r || out_ready;
  assign issue = adv && !q_stat.empty;
  assign q_pop = issue && (corner_r == CORNER_LT);

  assign use_right  = (corner_r == CORNER_RT) || (corner_r == CORNER_RB);
  assign use_bottom = (corner_r == CORNER_RB) || (corner_r == CORNER_LB);

  assign scale30  = {cfg.glyph_scale, 5'b0} - {4'b0, cfg.glyph_scale, 1'b0};
  assign scale120 = {cfg.glyph_scale, 7'b0} - {4'b0, cfg.glyph_scale, 3'b0};

  assign ax_sel = q_item.ax + (use_right ? $signed({5'b0, scale30}) : $signed(22'd0));
  assign ny_sel = q_item.ny + (use_bottom ? $signed({9'b0, scale120}) : $signed(28'd0));

  // round-half-up of v*4/5 is floor((4v+2)/5); of v*4/15 is floor((4v+7)/15)
  assign m_x      = $signed({ax_sel, 2'b10});
  assign m_y      = $signed({ny_sel, 2'b00}) + 30'sd7;
  assign u_x_full = m_x + SAT_X_HI;
  assign u_y_full = m_y + SAT_Y_HI;

  assign col   = q_item.code[3:0];
  assign row   = q_item.code[7:4];
  assign colp1 = {1'b0, col} + 5'd1;
  assign rowp1 = {1'b0, row} + 5'd1;

  assign tu_l      = {1'b0, col, 12'b0} + {1'b0, cfg.half_texel_u};
  assign tv_t      = {1'b0, row, 12'b0} + {1'b0, cfg.half_texel_v};
  assign tu_r_full = $signed({1'b0, colp1, 12'b0}) - $signed({2'b0, cfg.half_texel_u});
  assign tv_b_full = $signed({1'b0, rowp1, 12'b0}) - $signed({2'b0, cfg.half_texel_v});
  assign tu_r      = tu_r_full[TEX_W] ? '0 : tu_r_full[TEX_W-1:0];
  assign tv_b      = tv_b_full[TEX_W] ? '0 : tv_b_full[TEX_W-1:0];

  assign prod_x = {{RECIP_W{1'b0}}, s1_ux_r} * {{UX_W{1'b0}}, RECIP_X};
  assign prod_y = {{RECIP_W{1'b0}}, s1_uy_r} * {{UY_W{1'b0}}, RECIP_Y};

  // quotient is offset by 2^19; flipping the top bit removes it
  always_comb begin
    if (s2_brk_r) begin
      px = '0;
    end else if (s2_hi_x_r) begin
      px = POS_MAX;
    end else if (s2_lo_x_r) begin
      px = POS_MIN;
    end else begin
      px = $signed({~s2_qx_r[POS_W-1], s2_qx_r[POS_W-2:0]});
    end
    if (s2_brk_r) begin
      py = '0;
    end else if (s2_hi_y_r) begin
      py = POS_MAX;
    end else if (s2_lo_y_r) begin
      py = POS_MIN;
    end else begin
      py = $signed({~s2_qy_r[POS_W-1], s2_qy_r[POS_W-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r    <= CORNER_RT;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (issue) begin
        corner_r <= corner_r + 1'b1;
      end
      if (adv) begin
        s1_v_r      <= issue;
        s2_v_r      <= s1_v_r;
        out_valid_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_corner_r <= corner_r;
      s1_brk_r    <= q_item.brk;
      s1_hi_x_r   <= (m_x >= SAT_X_HI);
      s1_lo_x_r   <= (m_x < SAT_X_LO);
      s1_hi_y_r   <= (m_y >= SAT_Y_HI);
      s1_lo_y_r   <= (m_y < SAT_Y_LO);
      s1_ux_r     <= u_x_full[UX_W-1:0];
      s1_uy_r     <= u_y_full[UY_W-1:0];
      s1_tu_r     <= use_right ? tu_r : tu_l;
      s1_tv_r     <= use_bottom ? tv_b : tv_t;

      s2_corner_r <= s1_corner_r;
      s2_brk_r    <= s1_brk_r;
      s2_hi_x_r   <= s1_hi_x_r;
      s2_lo_x_r   <= s1_lo_x_r;
      s2_hi_y_r   <= s1_hi_y_r;
      s2_lo_y_r   <= s1_lo_y_r;
      s2_qx_r     <= prod_x[RECIP_X_SH +: POS_W];
      s2_qy_r     <= prod_y[RECIP_Y_SH +: POS_W];
      s2_tu_r     <= s1_tu_r;
      s2_tv_r     <= s1_tv_r;

      out_corner_r <= s2_corner_r;
      out_pos_x_r  <= px;
      out_pos_y_r  <= py;
      out_tex_u_r  <= s2_tu_r;
      out_tex_v_r  <= s2_tv_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_corner = out_corner_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;
  assign out_tex_u  = out_tex_u_r;
  assign out_tex_v  = out_tex_v_r;
  assign out_last   = (out_corner_r == CORNER_LT);
  // ARGB to RGBA
  assign out_rgba   = {cfg.text_color[23:0], cfg.text_color[31:24]};

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for glyph_quad_layout: streams character codes in and
// checks every quad vertex against an in-bench layout predictor.
// Depends on glq_pkg (rtl/glq_pkg.sv) and the glyph_quad_layout RTL.
module testbench;
  import glq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint POS_TOP = 524287;
  localparam longint POS_BOT = -524288;

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic [RGBA_W-1:0]   rgba;
    logic                last;
  } vertex_t;

  // one directed character; rt_* is the right-top vertex where typed is set
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              eos;
    logic              typed;
    logic [POS_W-1:0]  rt_x;
    logic [POS_W-1:0]  rt_y;
    logic [TEX_W-1:0]  rt_u;
    logic [TEX_W-1:0]  rt_v;
  } text_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [CORNER_W-1:0] out_tuser;
  logic out_tlast;

  glyph_quad_layout uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and pen
  logic signed [10:0] org_x = 11'sd0;
  logic signed [10:0] org_y = 11'sd0;
  logic [11:0] scale = 12'd256;
  logic [31:0] color = 32'hFFFF_FFFF;
  logic [15:0] inset_u = 16'd128;
  logic [15:0] inset_v = 16'd128;
  logic [PEN_X_W-1:0] pen_x = '0;
  logic [PEN_Y_W-1:0] pen_y = '0;

  vertex_t vertex_q [$];
  int mismatches = 0;
  int send_gap_pct = 0;
  int sink_gap_pct = 0;

  text_row_t opening_text [23] = '{
    '{"A",     1'b1, 1'b1, 20'd4096, -20'sd1229, 17'd8064,  17'd16512},
    '{8'h00,   1'b1, 1'b1, 20'd4096, -20'sd1229, 17'd3968,  17'd128},
    '{8'hFF,   1'b1, 1'b1, 20'd4096, -20'sd1229, 17'd65408, 17'd61568},
    '{CHAR_CR, 1'b0, 1'b1, 20'd0,    20'd0,      17'd57216, 17'd128},
    '{CHAR_LF, 1'b1, 1'b1, 20'd0,    20'd0,      17'd44928, 17'd128},
    '{"W",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"i",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"m",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"R",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"s",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"r",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"d",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"7",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"t",     1'b0, 1'b0, '0, '0, '0, '0},
    '{"x",     1'b0, 1'b0, '0, '0, '0, '0},
    '{8'h80,   1'b0, 1'b0, '0, '0, '0, '0},   // high codes: unsigned, default advance
    '{8'hE9,   1'b0, 1'b0, '0, '0, '0, '0},
    '{CHAR_LF, 1'b0, 1'b0, '0, '0, '0, '0},
    '{"A",     1'b0, 1'b0, '0, '0, '0, '0},
    '{CHAR_CR, 1'b0, 1'b0, '0, '0, '0, '0},
    '{8'h7F,   1'b1, 1'b0, '0, '0, '0, '0},
    '{8'hAA,   1'b0, 1'b0, '0, '0, '0, '0},
    '{8'h55,   1'b1, 1'b0, '0, '0, '0, '0}
  };

  function automatic int glyph_advance(input logic [7:0] ch);
    case (ch)
      "i", "l", "I", " ", "/", "\\", ";", ":", ".", ",":           return 5;
      "[", "]", "|", "(", ")", "j", "f", "t":                     return 6;
      "d", "h", "o", "p", "n", "F", "+":                          return 11;
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
      "e", "k", "a", "c", "u", "y", "v", "L":                     return 10;
      "s":                                                        return 9;
      "r", "J", "-", "=":                                         return 8;
      "W":                                                        return 17;
      "m", "w", "M", "N":                                         return 15;
      "R":                                                        return 13;
      default:                                                    return 12;
    endcase
  endfunction

  // num*mul/den rounded to nearest (ties up), clamped to Q4.16
  function automatic longint round_clamp(input longint num, input longint mul,
                                         input longint den);
    longint n, d, q;
    n = 2 * num * mul + den;
    d = 2 * den;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    if (q > POS_TOP) q = POS_TOP;
    if (q < POS_BOT) q = POS_BOT;
    return q;
  endfunction

  function automatic logic [TEX_W-1:0] tex_clip(input longint t);
    return (t < 0) ? '0 : t[TEX_W-1:0];
  endfunction

  // lay out one character: queue its four vertices, then move the pen
  function automatic void layout_glyph(input logic [7:0] code, input logic eos);
    logic brk, xs, ys;
    longint ax, ny;
    longint px [2];
    longint py [2];
    longint tu [2];
    longint tv [2];
    logic [31:0] nx;
    logic [16:0] ny_pen;
    vertex_t v;
    brk = (code == CHAR_LF) || (code == CHAR_CR);
    ax = longint'(org_x) * 256 + longint'(pen_x) - 2560;
    ny = 1024 * (longint'(org_y) + longint'(pen_y)) - 4608;
    px[0] = brk ? 0 : round_clamp(ax, 4, 5);
    px[1] = brk ? 0 : round_clamp(ax + 30 * longint'(scale), 4, 5);
    py[0] = brk ? 0 : round_clamp(ny, 4, 15);
    py[1] = brk ? 0 : round_clamp(ny + 120 * longint'(scale), 4, 15);
    tu[0] = longint'(code[3:0]) * 4096 + longint'(inset_u);
    tu[1] = (longint'(code[3:0]) + 1) * 4096 - longint'(inset_u);
    tv[0] = longint'(code[7:4]) * 4096 + longint'(inset_v);
    tv[1] = (longint'(code[7:4]) + 1) * 4096 - longint'(inset_v);
    for (int k = 0; k < 4; k++) begin
      v.corner = (k == 0) ? CORNER_RT : (k == 1) ? CORNER_RB :
                 (k == 2) ? CORNER_LB : CORNER_LT;
      xs = (v.corner == CORNER_RT) || (v.corner == CORNER_RB);
      ys = (v.corner == CORNER_RB) || (v.corner == CORNER_LB);
      v.pos_x = px[xs][POS_W-1:0];
      v.pos_y = py[ys][POS_W-1:0];
      v.tex_u = tex_clip(tu[xs]);
      v.tex_v = tex_clip(tv[ys]);
      v.rgba = {color[23:0], color[31:24]};
      v.last = (v.corner == CORNER_LT);
      vertex_q.push_back(v);
    end
    if (brk) begin
      pen_x = '0;
      ny_pen = {1'b0, pen_y} + 17'd16;
      pen_y = ny_pen[16] ? 16'hFFFF : ny_pen[15:0];
    end else begin
      nx = 32'(pen_x) + 32'(glyph_advance(code)) * 32'(scale);
      pen_x = (nx > 32'hF_FFFF) ? 20'hF_FFFF : nx[PEN_X_W-1:0];
    end
    if (eos) begin
      pen_x = '0;
      pen_y = '0;
    end
  endfunction

  // leaves cfg_we high; caller lowers it after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_ORIGIN_X:     org_x = val[10:0];
      REG_ORIGIN_Y:     org_y = val[10:0];
      REG_GLYPH_SCALE:  scale = val[11:0];
      REG_TEXT_COLOR:   color = val;
      REG_HALF_TEXEL_U: inset_u = val[15:0];
      REG_HALF_TEXEL_V: inset_v = val[15:0];
      default: ;
    endcase
  endtask

  // random junk above each register's width checks the masking
  task automatic load_config(input logic [10:0] ox, input logic [10:0] oy,
                             input logic [11:0] sc, input logic [31:0] col,
                             input logic [15:0] hu, input logic [15:0] hv);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_ORIGIN_X, {junk[31:11], ox});
    write_reg(REG_ORIGIN_Y, {junk[20:0], oy});
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_GLYPH_SCALE, {junk[19:0], sc});
    write_reg(REG_TEXT_COLOR, col);
    write_reg(REG_SPARE_HI, $urandom);
    write_reg(REG_HALF_TEXEL_U, {junk[31:16], hu});
    write_reg(REG_HALF_TEXEL_V, {junk[15:0], hv});
    cfg_we <= 1'b0;
  endtask

  task automatic send_char(input logic [7:0] code, input logic eos);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= code;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    layout_glyph(code, eos);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(32, 126));
    if (r < 70) return $urandom_range(1) ? CHAR_CR : CHAR_LF;
    return 8'($urandom_range(255));
  endfunction

  // strings of random length closed by end_of_string, plus a few stray ends
  task automatic send_strings(input int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(1, 40);
      if (len > count - sent) len = count - sent;
      for (int j = 0; j < len; j++) begin
        send_char(pick_code(), (j == len - 1) || ($urandom_range(29) == 0));
      end
      sent += len;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_gap_pct);
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[19:0], out_tdata[39:20], out_tdata[56:40],
              out_tdata[73:57], out_tdata[105:74], out_tlast};
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex: corner %0d x %h y %h u %h v %h rgba %h last %0d",
                   got.corner, got.pos_x, got.pos_y, got.tex_u, got.tex_v, got.rgba, got.last);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("vertex mismatch at %0t", $realtime);
            $display("  expected corner %0d x %h y %h u %h v %h rgba %h last %0d",
                     want.corner, want.pos_x, want.pos_y, want.tex_u, want.tex_v,
                     want.rgba, want.last);
            $display("  actual   corner %0d x %h y %h u %h v %h rgba %h last %0d",
                     got.corner, got.pos_x, got.pos_y, got.tex_u, got.tex_v,
                     got.rgba, got.last);
          end
        end
      end
    end
  end

  initial begin
    text_row_t row;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed text at reset defaults
    send_gap_pct = 21;
    sink_gap_pct = 54;
    foreach (opening_text[i]) begin
      row = opening_text[i];
      send_char(row.code, row.eos);
      if (row.typed) begin
        // right-top vertex is the oldest of the four just queued
        vertex_q[vertex_q.size() - 4].pos_x = row.rt_x;
        vertex_q[vertex_q.size() - 4].pos_y = row.rt_y;
        vertex_q[vertex_q.size() - 4].tex_u = row.rt_u;
        vertex_q[vertex_q.size() - 4].tex_v = row.rt_v;
      end
    end
    drain();

    load_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                12'($urandom_range(1, 1023)), $urandom,
                16'($urandom_range(4096)), 16'($urandom_range(4096)));
    send_strings(110);
    drain();

    // upper extremes; horizontal inset past its range drives tex_u below zero
    send_gap_pct = 54;
    sink_gap_pct = 21;
    load_config(11'sd1023, 11'sd1023, 12'hFFF, 32'h0000_0000, 16'hFFFF, 16'h8000);
    send_strings(110);
    drain();

    send_gap_pct = 0;
    sink_gap_pct = 0;
    load_config(-11'sd1024, -11'sd1024, 12'h000, 32'h5AC3_0FF0, 16'h0000, 16'h0000);
    send_strings(40);
    drain();

    load_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                12'($urandom), $urandom, 16'($urandom), 16'($urandom_range(32768)));
    send_strings(45);
    // a few line breaks mid-string, then text below them
    for (int i = 0; i < 3; i++) send_char($urandom_range(1) ? CHAR_CR : CHAR_LF, 1'b0);
    for (int i = 0; i < 5; i++) send_char(8'($urandom_range(32, 126)), 1'b0);
    send_char(8'($urandom_range(32, 126)), 1'b1);
    drain();
    repeat (12) @(posedge clk);

    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("glyph_quad_layout regression: pass");
    end else begin
      $display("glyph_quad_layout regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("glyph_quad_layout regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/glq_pkg.sv
rtl/glq_front.sv
rtl/glq_queue.sv
rtl/glq_back.sv
rtl/glyph_quad_layout.sv
tb/testbench.sv
